// ===== src/motor_axis_safety_monitor_unit_defines.svh =====
// ---------------------------------------------------------------------------
// motor axis safety monitor assertion macros
// assertion forms used by the checker file
// ---------------------------------------------------------------------------
`ifndef MOTOR_AXIS_SAFETY_MONITOR_UNIT_DEFINES_SVH
`define MOTOR_AXIS_SAFETY_MONITOR_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define MSM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("msm assertion failed");

// next-cycle implication, disabled in reset
`define MSM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("msm assertion failed");

`endif

// ===== src/msm_pkg.sv =====
// ---------------------------------------------------------------------------
// msm_pkg
// types, constants and helpers of the motor axis safety monitor
// ---------------------------------------------------------------------------
package msm_pkg;

    localparam int OVERCURRENT_SAMPLES = 3;
    localparam int OVERSPEED_SAMPLES   = 20;
    localparam int TRACKING_SAMPLES    = 100;
    localparam int BUS_FAULT_SAMPLES   = 100;
    localparam int SOFT_GUARD_UM       = 1000;

    localparam int OC_CNT_W  = $clog2(OVERCURRENT_SAMPLES + 1);
    localparam int OS_CNT_W  = $clog2(OVERSPEED_SAMPLES + 1);
    localparam int TR_CNT_W  = $clog2(TRACKING_SAMPLES + 1);
    localparam int BUS_CNT_W = $clog2(BUS_FAULT_SAMPLES + 1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_PEAK_LIMIT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUS_VOLTAGE_MIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BUS_VOLTAGE_MAX    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SOFT_MIN_UM        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SOFT_MAX_UM        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY_LIMIT     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACKING_LIMIT_UM  = 3'd6;

    localparam int FB_OC = 0;
    localparam int FB_UV = 1;
    localparam int FB_OV = 2;
    localparam int FB_OS = 3;
    localparam int FB_TR = 4;

    localparam logic [14:0]        CURRENT_PEAK_RESET  = 15'd32767;
    localparam logic [15:0]        BUS_MIN_RESET       = 16'd8000;
    localparam logic [15:0]        BUS_MAX_RESET       = 16'd30000;
    localparam logic signed [32:0] SOFT_LO_RESET       =
        -33'sd2147483648 - 33'(SOFT_GUARD_UM);
    localparam logic signed [32:0] SOFT_HI_RESET       =
        33'sd2147483647 + 33'(SOFT_GUARD_UM);
    localparam int                 VELOCITY_RESET      = 32767;
    localparam logic [16:0]        VEL_TRIP_RESET      = 17'(3 * VELOCITY_RESET);
    localparam logic [19:0]        TRACKING_RESET      = 20'd2000;

    typedef struct packed {
        logic signed [15:0] phase_u_ma;
        logic signed [15:0] phase_v_ma;
        logic signed [15:0] phase_w_ma;
        logic        [15:0] bus_voltage;
        logic               bus_voltage_valid;
        logic signed [31:0] position_um;
        logic signed [31:0] setpoint_um;
        logic signed [15:0] velocity;
        logic               homed;
        logic               in_motion;
        logic               homing_run;
        logic               fault_clear;
    } t_in_item;

    typedef struct packed {
        logic       inhibit;
        logic [4:0] fault_bits;
        logic       power_ready;
    } t_out_item;

    // guarded window and 1.5x trip are held pre-scaled
    typedef struct packed {
        logic        [14:0] current_peak_limit;
        logic        [15:0] bus_voltage_min;
        logic        [15:0] bus_voltage_max;
        logic signed [32:0] soft_lo_um;
        logic signed [32:0] soft_hi_um;
        logic        [16:0] vel_trip_x2;
        logic        [19:0] tracking_limit_um;
    } t_cfg;

    typedef struct packed {
        logic overcurrent;
        logic undervoltage;
        logic overvoltage;
        logic overspeed;
        logic tracking;
        logic outside;
        logic power_ready;
    } t_cond;

    function automatic logic [16:0] abs16(input logic signed [15:0] x);
        logic signed [16:0] s;
        s = {x[15], x};
        return s[16] ? 17'(-s) : 17'(s);
    endfunction

endpackage

// ===== src/msm_cond.sv =====
// ---------------------------------------------------------------------------
// msm_cond
// per-sample fault condition evaluation against the configured limits
// ---------------------------------------------------------------------------
module msm_cond (
    input  msm_pkg::t_in_item i_item,
    input  msm_pkg::t_cfg     i_cfg,
    output msm_pkg::t_cond    o_cond
);
    import msm_pkg::*;

    logic [16:0]        iu_mag;
    logic [16:0]        iv_mag;
    logic [16:0]        iw_mag;
    logic [16:0]        vel_mag;
    logic [16:0]        vel_x2;
    logic signed [32:0] pos_ext;
    logic signed [32:0] trk_diff;
    logic [32:0]        trk_mag;
    logic               uv;
    logic               ov;

    always_comb begin
        iu_mag   = abs16(i_item.phase_u_ma);
        iv_mag   = abs16(i_item.phase_v_ma);
        iw_mag   = abs16(i_item.phase_w_ma);
        vel_mag  = abs16(i_item.velocity);
        vel_x2   = {vel_mag[15:0], 1'b0};
        pos_ext  = {i_item.position_um[31], i_item.position_um};
        trk_diff = {i_item.setpoint_um[31], i_item.setpoint_um} - pos_ext;
        trk_mag  = trk_diff[32] ? 33'(-trk_diff) : 33'(trk_diff);

        uv = i_item.bus_voltage_valid && (i_item.bus_voltage < i_cfg.bus_voltage_min);
        ov = i_item.bus_voltage_valid && (i_item.bus_voltage > i_cfg.bus_voltage_max);

        o_cond.overcurrent  = (iu_mag > {2'b00, i_cfg.current_peak_limit})
                           || (iv_mag > {2'b00, i_cfg.current_peak_limit})
                           || (iw_mag > {2'b00, i_cfg.current_peak_limit});
        o_cond.undervoltage = uv;
        o_cond.overvoltage  = ov;
        o_cond.overspeed    = i_item.in_motion && (vel_x2 > i_cfg.vel_trip_x2);
        o_cond.tracking     = i_item.in_motion
                           && (trk_mag > {13'd0, i_cfg.tracking_limit_um});
        o_cond.outside      = (pos_ext < i_cfg.soft_lo_um) || (pos_ext > i_cfg.soft_hi_um);
        o_cond.power_ready  = i_item.bus_voltage_valid && !uv && !ov;
    end

endmodule

// ===== src/motor_axis_safety_monitor_unit.sv =====
// ---------------------------------------------------------------------------
// motor_axis_safety_monitor_unit
// debounced overcurrent, bus voltage, overspeed, tracking and soft travel window fault monitor
// ---------------------------------------------------------------------------
// Takes one sample transaction per clock while the output side is not stalled,
// and returns one result per sample through the input register and then the
// result register. The rate is set by the debounce counters and fault latch,
// which are updated once per sample. A stalled result is held in the output
// register while the next sample waits in the input register. Configuration writes
// take effect at once and should be made while no sample is in flight.
module motor_axis_safety_monitor_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [msm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [msm_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  msm_pkg::t_in_item                   i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output msm_pkg::t_out_item                  o_out_data
);
    import msm_pkg::*;

    t_cfg      r_cfg;
    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;

    logic [OC_CNT_W-1:0]  r_oc_cnt,  n_oc_cnt;
    logic [BUS_CNT_W-1:0] r_uv_cnt,  n_uv_cnt;
    logic [BUS_CNT_W-1:0] r_ov_cnt,  n_ov_cnt;
    logic [OS_CNT_W-1:0]  r_os_cnt,  n_os_cnt;
    logic [TR_CNT_W-1:0]  r_tr_cnt,  n_tr_cnt;
    logic [4:0]           r_faults,  n_faults;

    t_cond     cond;
    t_out_item n_out;
    logic      out_free;
    logic      advance;

    msm_cond u_msm_cond (
        .i_item (r_in),
        .i_cfg  (r_cfg),
        .o_cond (cond)
    );

    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;

    // debounce counters and fault latch
    always_comb begin
        n_faults = r_in.fault_clear ? 5'd0 : r_faults;

        if (cond.overcurrent) begin
            n_oc_cnt = (r_oc_cnt < OC_CNT_W'(OVERCURRENT_SAMPLES)) ? r_oc_cnt + 1'b1 : r_oc_cnt;
            if (n_oc_cnt == OC_CNT_W'(OVERCURRENT_SAMPLES)) begin
                n_faults[FB_OC] = 1'b1;
            end
        end else begin
            n_oc_cnt = '0;
        end

        if (cond.undervoltage) begin
            n_uv_cnt = (r_uv_cnt < BUS_CNT_W'(BUS_FAULT_SAMPLES)) ? r_uv_cnt + 1'b1 : r_uv_cnt;
            if (n_uv_cnt == BUS_CNT_W'(BUS_FAULT_SAMPLES)) begin
                n_faults[FB_UV] = 1'b1;
            end
        end else begin
            n_uv_cnt = '0;
        end

        if (cond.overvoltage) begin
            n_ov_cnt = (r_ov_cnt < BUS_CNT_W'(BUS_FAULT_SAMPLES)) ? r_ov_cnt + 1'b1 : r_ov_cnt;
            if (n_ov_cnt == BUS_CNT_W'(BUS_FAULT_SAMPLES)) begin
                n_faults[FB_OV] = 1'b1;
            end
        end else begin
            n_ov_cnt = '0;
        end

        n_os_cnt = '0;
        n_tr_cnt = '0;
        if (!r_in.homing_run) begin
            if (r_in.homed && cond.outside) begin
                n_faults[FB_TR] = 1'b1;
            end
            if (cond.overspeed) begin
                n_os_cnt = (r_os_cnt < OS_CNT_W'(OVERSPEED_SAMPLES)) ? r_os_cnt + 1'b1
                                                                      : r_os_cnt;
                if (n_os_cnt == OS_CNT_W'(OVERSPEED_SAMPLES)) begin
                    n_faults[FB_OS] = 1'b1;
                end
            end
            if (cond.tracking) begin
                n_tr_cnt = (r_tr_cnt < TR_CNT_W'(TRACKING_SAMPLES)) ? r_tr_cnt + 1'b1
                                                                     : r_tr_cnt;
                if (n_tr_cnt == TR_CNT_W'(TRACKING_SAMPLES)) begin
                    n_faults[FB_TR] = 1'b1;
                end
            end
        end

        n_out.fault_bits  = n_faults;
        n_out.power_ready = cond.power_ready;
        n_out.inhibit     = !cond.power_ready || (n_faults != 5'd0);
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.current_peak_limit <= CURRENT_PEAK_RESET;
            r_cfg.bus_voltage_min    <= BUS_MIN_RESET;
            r_cfg.bus_voltage_max    <= BUS_MAX_RESET;
            r_cfg.soft_lo_um         <= SOFT_LO_RESET;
            r_cfg.soft_hi_um         <= SOFT_HI_RESET;
            r_cfg.vel_trip_x2        <= VEL_TRIP_RESET;
            r_cfg.tracking_limit_um  <= TRACKING_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CURRENT_PEAK_LIMIT: begin
                    r_cfg.current_peak_limit <= i_cfg_data[14:0];
                end
                CFG_BUS_VOLTAGE_MIN: begin
                    r_cfg.bus_voltage_min <= i_cfg_data[15:0];
                end
                CFG_BUS_VOLTAGE_MAX: begin
                    r_cfg.bus_voltage_max <= i_cfg_data[15:0];
                end
                CFG_SOFT_MIN_UM: begin
                    r_cfg.soft_lo_um <= $signed({i_cfg_data[31], i_cfg_data})
                                      - 33'(SOFT_GUARD_UM);
                end
                CFG_SOFT_MAX_UM: begin
                    r_cfg.soft_hi_um <= $signed({i_cfg_data[31], i_cfg_data})
                                      + 33'(SOFT_GUARD_UM);
                end
                CFG_VELOCITY_LIMIT: begin
                    r_cfg.vel_trip_x2 <= {2'b00, i_cfg_data[14:0]}
                                       + {1'b0, i_cfg_data[14:0], 1'b0};
                end
                CFG_TRACKING_LIMIT_UM: begin
                    r_cfg.tracking_limit_um <= i_cfg_data[19:0];
                end
                default: begin
                end
            endcase
        end
    end

    // input register, state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_oc_cnt    <= '0;
            r_uv_cnt    <= '0;
            r_ov_cnt    <= '0;
            r_os_cnt    <= '0;
            r_tr_cnt    <= '0;
            r_faults    <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_oc_cnt    <= n_oc_cnt;
                r_uv_cnt    <= n_uv_cnt;
                r_ov_cnt    <= n_ov_cnt;
                r_os_cnt    <= n_os_cnt;
                r_tr_cnt    <= n_tr_cnt;
                r_faults    <= n_faults;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_in <= i_in_data;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== src/msm_checker.sv =====
// ---------------------------------------------------------------------------
// msm_checker
// port-level checks of the motor axis safety monitor, bound to the top level
// ---------------------------------------------------------------------------
`include "motor_axis_safety_monitor_unit_defines.svh"

module msm_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_cfg_we,
    input logic [msm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input logic [msm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input msm_pkg::t_in_item              i_in_data,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input msm_pkg::t_out_item             o_out_data
);
    import msm_pkg::*;

    // a stalled result transaction holds
    `MSM_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data))

    // inhibit follows bus state and latched faults
    `MSM_ASSERT_NOW(a_inhibit, o_out_valid, o_out_data.inhibit == (!o_out_data.power_ready || (o_out_data.fault_bits != 5'd0)))

    // an empty result register never blocks the input side
    `MSM_ASSERT_NOW(a_ready_when_empty, !o_out_valid, o_in_ready)

    // a sample accepted while no result is held passes the input register, then shows in the result register
    `MSM_ASSERT_NEXT(a_result_follows, i_in_valid && o_in_ready && !o_out_valid, 1'b1 ##1 o_out_valid)

endmodule

bind motor_axis_safety_monitor_unit msm_checker u_msm_checker (.*);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// motor axis safety monitor testbench
// Drives sample transactions through the valid/ready input channel with
// random gaps and output back-pressure, including one long receiver stall.
// A behavioural model of the debounce counters and fault latch predicts the
// status of every accepted sample, and each returned status is checked field
// by field. Directed samples hit field extremes, limit edges, fault clear,
// homing and invalid bus cases. Random sequences then hold fault conditions
// long enough to latch, across several limit settings that include the
// extremes and an inverted travel window.
// ---------------------------------------------------------------------------
module testbench;
    import msm_pkg::*;

    localparam int     LIMIT_CYCLES = 1000000;
    localparam int     DRAIN_CYCLES = 8;
    localparam int     PHASE_SAMPLES = 350;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam longint I32_MIN = -64'sd2147483648;
    localparam longint I32_MAX = 64'sd2147483647;

    // wanted condition bits for generated samples
    localparam int C_OC  = 0;
    localparam int C_UV  = 1;
    localparam int C_OV  = 2;
    localparam int C_OS  = 3;
    localparam int C_TR  = 4;
    localparam int C_OUT = 5;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_in_item              i_in_data = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_item             o_out_data;

    // model copy of the limits and monitor state
    logic [14:0] peak_ma;
    logic [15:0] bus_min_mv;
    logic [15:0] bus_max_mv;
    longint      soft_min;
    longint      soft_max;
    logic [14:0] speed_limit;
    logic [19:0] track_limit;
    int          trip_count [5];
    int          trip_samples [5];
    logic [4:0]  faults;

    t_in_item    pending_samples [$];
    t_out_item   expected_status [$];
    t_out_item   exp_status;
    int          mismatch_count = 0;
    int          results_seen = 0;
    int          cycle_count = 0;
    bit          in_taken = 1'b0;
    int          in_gap = 0;
    int          in_calm = 0;
    int          out_stall = 0;
    int          out_calm = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;

    motor_axis_safety_monitor_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic void reset_model();
        peak_ma     = 15'd32767;
        bus_min_mv  = 16'd8000;
        bus_max_mv  = 16'd30000;
        soft_min    = I32_MIN;
        soft_max    = I32_MAX;
        speed_limit = 15'd32767;
        track_limit = 20'd2000;
        faults      = '0;
        trip_samples[FB_OC] = OVERCURRENT_SAMPLES;
        trip_samples[FB_UV] = BUS_FAULT_SAMPLES;
        trip_samples[FB_OV] = BUS_FAULT_SAMPLES;
        trip_samples[FB_OS] = OVERSPEED_SAMPLES;
        trip_samples[FB_TR] = TRACKING_SAMPLES;
        for (int k = 0; k < 5; k++) trip_count[k] = 0;
    endfunction

    function automatic longint mag(longint x);
        return (x < 0) ? -x : x;
    endfunction

    function automatic void qualify(bit cond, int fb);
        if (cond) begin
            if (trip_count[fb] < trip_samples[fb]) trip_count[fb]++;
            if (trip_count[fb] >= trip_samples[fb]) faults[fb] = 1'b1;
        end else begin
            trip_count[fb] = 0;
        end
    endfunction

    function automatic t_out_item predict_status(t_in_item s);
        longint    imax;
        longint    pos;
        longint    sp;
        bit        uv;
        bit        ov;
        bit        outside;
        t_out_item r;
        if (s.fault_clear) faults = '0;
        imax = mag(longint'($signed(s.phase_u_ma)));
        if (mag(longint'($signed(s.phase_v_ma))) > imax) imax = mag(longint'($signed(s.phase_v_ma)));
        if (mag(longint'($signed(s.phase_w_ma))) > imax) imax = mag(longint'($signed(s.phase_w_ma)));
        uv = s.bus_voltage_valid && (s.bus_voltage < bus_min_mv);
        ov = s.bus_voltage_valid && (s.bus_voltage > bus_max_mv);
        qualify(imax > longint'(peak_ma), FB_OC);
        qualify(uv, FB_UV);
        qualify(ov, FB_OV);
        if (!s.homing_run) begin
            pos = longint'($signed(s.position_um));
            sp  = longint'($signed(s.setpoint_um));
            outside = (pos < soft_min - SOFT_GUARD_UM) || (pos > soft_max + SOFT_GUARD_UM);
            if (s.homed && outside) faults[FB_TR] = 1'b1;
            qualify(s.in_motion &&
                    (2 * mag(longint'($signed(s.velocity))) > 3 * longint'(speed_limit)), FB_OS);
            qualify(s.in_motion && (mag(sp - pos) > longint'(track_limit)), FB_TR);
        end else begin
            trip_count[FB_OS] = 0;
            trip_count[FB_TR] = 0;
        end
        r.fault_bits  = faults;
        r.power_ready = s.bus_voltage_valid && (s.bus_voltage >= bus_min_mv) &&
                        (s.bus_voltage <= bus_max_mv);
        r.inhibit     = !s.bus_voltage_valid || uv || ov || (faults != '0);
        return r;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            CFG_CURRENT_PEAK_LIMIT: peak_ma     = data[14:0];
            CFG_BUS_VOLTAGE_MIN:    bus_min_mv  = data[15:0];
            CFG_BUS_VOLTAGE_MAX:    bus_max_mv  = data[15:0];
            CFG_SOFT_MIN_UM:        soft_min    = longint'($signed(data));
            CFG_SOFT_MAX_UM:        soft_max    = longint'($signed(data));
            CFG_VELOCITY_LIMIT:     speed_limit = data[14:0];
            CFG_TRACKING_LIMIT_UM:  track_limit = data[19:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // unused upper bits carry random junk
    task automatic load_limits(input int peak, input int bmin, input int bmax,
                               input longint smin, input longint smax,
                               input int vel, input int trk);
        logic [31:0] d;
        d = $urandom(); d[14:0] = 15'(peak); write_reg(CFG_CURRENT_PEAK_LIMIT, d);
        d = $urandom(); d[15:0] = 16'(bmin); write_reg(CFG_BUS_VOLTAGE_MIN, d);
        d = $urandom(); d[15:0] = 16'(bmax); write_reg(CFG_BUS_VOLTAGE_MAX, d);
        write_reg(CFG_SOFT_MIN_UM, 32'(smin));
        write_reg(CFG_SOFT_MAX_UM, 32'(smax));
        d = $urandom(); d[14:0] = 15'(vel); write_reg(CFG_VELOCITY_LIMIT, d);
        d = $urandom(); d[19:0] = 20'(trk); write_reg(CFG_TRACKING_LIMIT_UM, d);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(3, 1);
        if (r < 97) return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic longint pick_between(longint lo, longint hi);
        if (hi <= lo) return lo;
        case ($urandom_range(7))
            0: return lo;
            1: return hi;
            default: return lo + longint'($urandom_range(32'(hi - lo)));
        endcase
    endfunction

    function automatic logic [31:0] clamp32(longint x);
        if (x > I32_MAX) return 32'(I32_MAX);
        if (x < I32_MIN) return 32'(I32_MIN);
        return 32'(x);
    endfunction

    // magnitude above bound when over is set and bound is under 32768, else at or below it
    function automatic logic [15:0] pick_signed16(longint bound, bit over);
        longint m;
        if (over && bound < 32768) m = pick_between(bound + 1, 32768);
        else m = pick_between(0, (bound < 32767) ? bound : 32767);
        if (m == 32768 || $urandom_range(1)) return 16'(-m);
        return 16'(m);
    endfunction

    function automatic t_in_item blank_sample();
        t_in_item s;
        s = '0;
        s.bus_voltage = 16'd12000;
        s.bus_voltage_valid = 1'b1;
        return s;
    endfunction

    function automatic t_in_item make_sample(logic [5:0] want);
        t_in_item s;
        int       hot;
        longint   lo;
        longint   hi;
        longint   pos;
        longint   d;
        hot = $urandom_range(2);
        s.phase_u_ma = pick_signed16(peak_ma, want[C_OC] && (hot == 0 || $urandom_range(3) == 0));
        s.phase_v_ma = pick_signed16(peak_ma, want[C_OC] && (hot == 1 || $urandom_range(3) == 0));
        s.phase_w_ma = pick_signed16(peak_ma, want[C_OC] && (hot == 2 || $urandom_range(3) == 0));
        if (want[C_UV] && bus_min_mv != 16'd0)
            s.bus_voltage = 16'(pick_between(0, longint'(bus_min_mv) - 1));
        else if (want[C_OV] && bus_max_mv != 16'hFFFF)
            s.bus_voltage = 16'(pick_between(longint'(bus_max_mv) + 1, 65535));
        else if (bus_min_mv <= bus_max_mv)
            s.bus_voltage = 16'(pick_between(bus_min_mv, bus_max_mv));
        else
            s.bus_voltage = 16'($urandom());
        if (want[C_UV] || want[C_OV]) s.bus_voltage_valid = ($urandom_range(255) != 0);
        else s.bus_voltage_valid = ($urandom_range(31) != 0);
        lo = soft_min - SOFT_GUARD_UM;
        hi = soft_max + SOFT_GUARD_UM;
        if (want[C_OUT] && lo > I32_MIN && (hi >= I32_MAX || $urandom_range(1)))
            pos = pick_between(I32_MIN, lo - 1);
        else if (want[C_OUT] && hi < I32_MAX)
            pos = pick_between(hi + 1, I32_MAX);
        else if (lo <= hi)
            pos = pick_between((lo < I32_MIN) ? I32_MIN : lo, (hi > I32_MAX) ? I32_MAX : hi);
        else
            pos = longint'($signed(32'($urandom())));
        s.position_um = 32'(pos);
        if (want[C_TR]) d = pick_between(longint'(track_limit) + 1, longint'(track_limit) + 200000);
        else d = pick_between(0, track_limit);
        if ($urandom_range(1)) d = -d;
        s.setpoint_um = clamp32(pos + d);
        s.velocity = pick_signed16((3 * longint'(speed_limit)) / 2, want[C_OS]);
        s.homed = ($urandom_range(3) != 0);
        if (want[C_OS] || want[C_TR]) s.in_motion = ($urandom_range(255) != 0);
        else s.in_motion = ($urandom_range(3) != 0);
        s.homing_run = 1'b0;
        s.fault_clear = ($urandom_range(63) == 0);
        return s;
    endfunction

    task automatic queue_random(int count);
        int           made;
        int           run;
        int           kind;
        int           r;
        logic [5:0]   want;
        logic [159:0] raw;
        t_in_item     s;
        made = 0;
        while (made < count) begin
            kind = $urandom_range(9);
            want = '0;
            run = $urandom_range(20, 1);
            if (kind >= 2 && kind <= 6) begin
                want = 6'(1 << $urandom_range(5));
                if ($urandom_range(2) == 0) want |= 6'(1 << $urandom_range(5));
                r = $urandom_range(9);
                if (r < 5) run = $urandom_range(12, 1);
                else if (r < 8) run = $urandom_range(40, 13);
                else run = $urandom_range(125, 95);
            end else if (kind == 7) begin
                run = $urandom_range(8, 1);
            end else if (kind == 8) begin
                want = 6'($urandom());
                run = $urandom_range(30, 1);
            end else if (kind == 9) begin
                want = 6'($urandom());
                run = 1;
            end
            for (int k = 0; k < run; k++) begin
                if (kind == 7) begin
                    raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
                    s = raw[$bits(t_in_item)-1:0];
                end else if ($urandom_range(40) == 0) begin
                    s = make_sample(want & 6'($urandom()));
                end else begin
                    s = make_sample(want);
                end
                if (kind == 8) s.homing_run = 1'b1;
                if (kind == 9) s.fault_clear = 1'b1;
                pending_samples.push_back(s);
            end
            made += run;
        end
    endtask

    task automatic wait_idle();
        while (pending_samples.size() != 0 || i_in_valid || expected_status.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic report_mismatch(string what, int got, int want_v);
        if (mismatch_count < 50)
            $display("mismatch on result %0d: %s got %0h expected %0h",
                     results_seen, what, got, want_v);
        mismatch_count++;
    endtask

    // sample transaction driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            in_taken = 1'b0;
            if (in_gap > 0) begin
                in_gap--;
                i_in_valid <= 1'b0;
            end else if (pending_samples.size() != 0) begin
                i_in_data  <= pending_samples.pop_front();
                i_in_valid <= 1'b1;
                if (in_calm > 0) begin
                    in_calm--;
                end else begin
                    in_gap = pick_gap();
                    if ($urandom_range(40) == 0) in_calm = $urandom_range(100, 20);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // status receiver, with one long hold-off so the input side backs up
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (!hold_done && results_seen >= 600) begin
            hold_done = 1'b1;
            hold_left = 300;
            i_out_ready <= 1'b0;
        end else if (out_stall > 0) begin
            out_stall--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if (out_calm > 0) begin
                out_calm--;
            end else begin
                out_stall = pick_gap();
                if ($urandom_range(40) == 0) out_calm = $urandom_range(100, 20);
            end
        end
    end

    // monitor of both channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                expected_status.push_back(predict_status(i_in_data));
                in_taken = 1'b1;
            end
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (expected_status.size() == 0) begin
                    report_mismatch("unexpected transaction", int'(o_out_data), 0);
                end else begin
                    exp_status = expected_status.pop_front();
                    if (o_out_data.inhibit !== exp_status.inhibit)
                        report_mismatch("inhibit", o_out_data.inhibit, exp_status.inhibit);
                    if (o_out_data.fault_bits !== exp_status.fault_bits)
                        report_mismatch("fault_bits", o_out_data.fault_bits, exp_status.fault_bits);
                    if (o_out_data.power_ready !== exp_status.power_ready)
                        report_mismatch("power_ready", o_out_data.power_ready,
                                        exp_status.power_ready);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        t_in_item s;
        longint   lo_um;
        longint   hi_um;
        longint   tmp;
        reset_model();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset limits: field extremes, overcurrent latch and fault clear
        s = blank_sample(); pending_samples.push_back(s);
        s.bus_voltage_valid = 1'b0; s.bus_voltage = '0; pending_samples.push_back(s);
        s = blank_sample(); s.phase_u_ma = 16'h8000; repeat (3) pending_samples.push_back(s);
        s.phase_u_ma = '0; s.phase_w_ma = 16'h8000; s.fault_clear = 1'b1;
        pending_samples.push_back(s);
        s = blank_sample(); s.fault_clear = 1'b1; pending_samples.push_back(s);
        s = blank_sample(); s.phase_u_ma = 16'h7FFF; s.phase_v_ma = 16'h8001;
        s.bus_voltage = 16'hFFFF; pending_samples.push_back(s);
        s.bus_voltage = 16'd0; pending_samples.push_back(s);
        s.bus_voltage = 16'd8000; pending_samples.push_back(s);
        s.bus_voltage = 16'd30000; pending_samples.push_back(s);
        s = blank_sample(); s.position_um = 32'h8000_0000; s.setpoint_um = 32'h7FFF_FFFF;
        s.in_motion = 1'b1; s.homed = 1'b1; s.velocity = 16'h8000;
        pending_samples.push_back(s);
        s.position_um = 32'h7FFF_FFFF; s.setpoint_um = 32'h8000_0000; s.velocity = 16'h7FFF;
        pending_samples.push_back(s);
        wait_idle();

        // typical limits: window edges, homing, motion and invalid bus
        load_limits(10000, 12000, 36000, -50000000, 50000000, 1000, 2000);
        write_reg(CFG_UNUSED, 32'd0);
        s = blank_sample(); s.homed = 1'b1; s.position_um = 32'sd50001000;
        s.setpoint_um = 32'sd50001000; pending_samples.push_back(s);
        s.position_um = 32'sd50001001; pending_samples.push_back(s);
        s.fault_clear = 1'b1; s.homing_run = 1'b1; pending_samples.push_back(s);
        s.homing_run = 1'b0; s.homed = 1'b0; pending_samples.push_back(s);
        s = blank_sample(); s.velocity = 16'h8000; pending_samples.push_back(s);
        s.in_motion = 1'b1; s.velocity = 16'sd1501; pending_samples.push_back(s);
        s.velocity = 16'sd1500; pending_samples.push_back(s);
        s = blank_sample(); s.bus_voltage_valid = 1'b0; pending_samples.push_back(s);
        s = blank_sample(); s.homed = 1'b1; s.position_um = -32'sd50001001;
        s.setpoint_um = -32'sd50001001; pending_samples.push_back(s);
        queue_random(PHASE_SAMPLES);
        wait_idle();

        // all limits at their low extreme
        load_limits(0, 0, 0, 0, 0, 0, 0);
        queue_random(PHASE_SAMPLES);
        wait_idle();

        // limits at their high extreme, with the bus minimum at zero
        load_limits(32767, 0, 65535, I32_MIN, I32_MAX, 32767, 1048575);
        queue_random(PHASE_SAMPLES);
        wait_idle();

        // random limits
        lo_um = longint'($signed(32'($urandom())));
        hi_um = longint'($signed(32'($urandom())));
        if (lo_um > hi_um) begin
            tmp = lo_um; lo_um = hi_um; hi_um = tmp;
        end
        load_limits($urandom_range(32767), $urandom_range(65535), $urandom_range(65535),
                    lo_um, hi_um, $urandom_range(32767), $urandom_range(1048575));
        queue_random(PHASE_SAMPLES);
        wait_idle();

        // inverted travel window and bus limits
        load_limits($urandom_range(20000, 100), 40000, 20000, 1000000, -1000000,
                    $urandom_range(5000, 1), $urandom_range(100000));
        queue_random(PHASE_SAMPLES);
        wait_idle();

        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
